[design/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants and types for the lap time statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lts_pkg;

  // Lap and statistics sizing.
  localparam int LAP_BITS = 32;
  localparam int LAP_W    = 32;
  localparam int CNT_W    = 16;
  localparam int US_W     = 23;
  localparam int DEV_W    = 31;

  localparam logic [LAP_W-1:0] LAP_MASK = LAP_W'((64'd1 << LAP_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] MAX_LAPS = 16'd65535;
  localparam logic [CNT_W-1:0] MIN_FOR_DEV = 16'd2;
  localparam logic [15:0] NS_PER_US = 16'd1000;
  localparam logic [DEV_W-1:0] DEV_MAX = '1;

  // Divider sizing: 64-bit dividend, 16-bit divisor, two quotient bits per cycle.
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 16;
  localparam int PAIR_W = 6;

  // Quotient bit pairs needed for each dividend width.
  localparam logic [PAIR_W-1:0] PAIRS_32 = 6'd16;
  localparam logic [PAIR_W-1:0] PAIRS_48 = 6'd24;
  localparam logic [PAIR_W-1:0] PAIRS_64 = 6'd32;

  typedef struct packed {
    logic              start;
    logic [PAIR_W-1:0] pairs;
  } div_req_t;

endpackage

[design/lts_div.sv]
// ----------------------------------------------------------------------------
// lts_div
// Shared restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_div
  import lts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quo,
  output logic [DVS_W-1:0] rmd,
  output logic             done
);

  logic              busy;
  logic [PAIR_W-1:0] cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  align;

  logic [DVS_W:0]    t1, t2;
  logic              ge1, ge2;
  logic [DVS_W-1:0]  r1, r2;

  // The dividend is left-aligned so that its top bit is taken first.
  assign align = dividend << {6'(6'd32 - req.pairs), 1'b0};

  always_comb begin
    t1  = {rmd, dvd[DVD_W-1]};
    ge1 = (t1 >= {1'b0, dvs});
    r1  = ge1 ? DVS_W'(t1 - {1'b0, dvs}) : t1[DVS_W-1:0];
    t2  = {r1, dvd[DVD_W-2]};
    ge2 = (t2 >= {1'b0, dvs});
    r2  = ge2 ? DVS_W'(t2 - {1'b0, dvs}) : t2[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.pairs;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= align;
      dvs <= divisor;
      quo <= '0;
      rmd <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-3:0], 2'b00};
      quo <= {quo[DVD_W-3:0], ge1, ge2};
      rmd <= r2;
    end
  end

endmodule

[design/lts_mul.sv]
// ----------------------------------------------------------------------------
// lts_mul
// Shared 24 x 24 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_mul
  import lts_pkg::*;
(
  input  logic        clk,
  input  logic [23:0] a,
  input  logic [23:0] b,
  output logic [47:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[design/lts_sqrt.sv]
// ----------------------------------------------------------------------------
// lts_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_sqrt
  import lts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [35:0] rem_try;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_new;

  always_comb begin
    rem_try = {rem, rad[63:62]};
    trial   = {2'b00, root, 2'b01};
    ge      = (rem_try >= trial);
    rem_new = ge ? (rem_try - trial) : rem_try;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= rem_new[33:0];
      root <= {root[30:0], ge};
    end
  end

endmodule

[design/lap_time_statistics_core.sv]
// ----------------------------------------------------------------------------
// lap_time_statistics_core
// Running count, min, max, mean and sample standard deviation of lap times.
//
// Each input request carries one lap duration in ns. Unless the lap count
// has reached its limit, the lap is added to the running sums; otherwise it
// is dropped and the sticky overflowed flag is set. Every request yields one
// result with the count, truncated mean in ns and whole us, shortest and
// longest lap, and the sample deviation in us with 8 fraction bits.
// The next request can be taken in the cycle after the result is loaded. Fewer
// than two laps, a dropped lap or a saturated variance skip steps. The work
// is done by the shared divider, which yields two quotient bits per cycle
// over five divisions, and by the square root unit, one bit per cycle.
// in_stall is high for the whole computation, so one request is in work at
// a time. The result sits in an output register: a new request is taken
// while it waits, and a finished result waits for out_stall to drop.
// Reset clears the statistics (shortest starts at all ones) and the flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap_time_statistics_core
  import lts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [LAP_W-1:0] lap_ns,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] lap_total,
  output logic [31:0]      mean_ns,
  output logic [US_W-1:0]  mean_us,
  output logic [31:0]      shortest_ns,
  output logic [31:0]      longest_ns,
  output logic [DEV_W-1:0] deviation_us_q8,
  output logic             overflowed
);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_US_GO     = 19'h00002,
    S_US_WAIT   = 19'h00004,
    S_UPDATE    = 19'h00008,
    S_MEAN_GO   = 19'h00010,
    S_MEAN_WAIT = 19'h00020,
    S_MUS_GO    = 19'h00040,
    S_MUS_WAIT  = 19'h00080,
    S_NM        = 19'h00100,
    S_MU        = 19'h00200,
    S_C0        = 19'h00400,
    S_C1        = 19'h00800,
    S_C2        = 19'h01000,
    S_C3        = 19'h02000,
    S_VQ_GO     = 19'h04000,
    S_VQ_WAIT   = 19'h08000,
    S_VR_WAIT   = 19'h10000,
    S_RT_WAIT   = 19'h20000,
    S_FIN       = 19'h40000
  } state_t;

  state_t state, state_next;

  // Running statistics.
  logic [CNT_W-1:0] tally;
  logic [47:0]      sum_ns;
  logic [38:0]      sum_us;
  logic [60:0]      sum_sq;
  logic [31:0]      min_seen;
  logic [31:0]      max_seen;
  logic             drop_flag;

  // Per-request working registers.
  logic [LAP_W-1:0] lap;
  logic [31:0]      avg_ns;
  logic [US_W-1:0]  avg_us;
  logic [63:0]      u;
  logic [63:0]      acc;
  logic [63:0]      vq;
  logic [DEV_W-1:0] dev;

  // Shared units.
  div_req_t         div_req;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] div_q;
  logic [DVS_W-1:0] div_r;
  logic             div_done;
  logic [23:0]      mul_a, mul_b;
  logic [47:0]      mul_p;
  logic             rt_start;
  logic [31:0]      rt_root;
  logic             rt_done;
  logic [US_W-1:0]  us;

  logic in_take;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign us       = div_q[US_W-1:0];
  assign rt_start = (state == S_VR_WAIT) && div_done && (vq[63:48] == '0);

  lts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (div_q),
    .rmd      (div_r),
    .done     (div_done)
  );

  lts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  lts_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand ({vq[47:0], div_q[15:0]}),
    .root     (rt_root),
    .done     (rt_done)
  );

  // Divider requests.
  always_comb begin
    div_req.start = 1'b0;
    div_req.pairs = PAIRS_32;
    div_dvd       = '0;
    div_dvs       = NS_PER_US;
    unique case (state)
      S_US_GO: begin
        div_req.start = (tally < MAX_LAPS);
        div_dvd       = {32'b0, lap};
      end
      S_MEAN_GO: begin
        div_req.start = (tally != '0);
        div_req.pairs = PAIRS_48;
        div_dvd       = {16'b0, sum_ns};
        div_dvs       = tally;
      end
      S_MUS_GO: begin
        div_req.start = 1'b1;
        div_dvd       = {32'b0, avg_ns};
      end
      S_VQ_GO: begin
        div_req.start = 1'b1;
        div_req.pairs = PAIRS_64;
        div_dvd       = acc;
        div_dvs       = tally - 1'b1;
      end
      S_VQ_WAIT: begin
        // Fraction bits of the variance: remainder scaled by 2^16 over n-1.
        div_req.start = div_done;
        div_dvd       = {16'b0, div_r, 16'b0};
        div_dvs       = tally - 1'b1;
      end
      default: ;
    endcase
  end

  // Multiplier operands; the product is registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state) inside
      S_US_WAIT, S_UPDATE: begin
        mul_a = {1'b0, us};
        mul_b = {1'b0, us};
      end
      S_NM: begin
        mul_a = {8'b0, tally};
        mul_b = {1'b0, avg_us};
      end
      S_C0: begin
        mul_a = {1'b0, avg_us};
        mul_b = u[23:0];
      end
      S_C1: begin
        mul_a = {1'b0, avg_us};
        mul_b = u[47:24];
      end
      S_C2: begin
        mul_a = {1'b0, avg_us};
        mul_b = {8'b0, u[63:48]};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_take) state_next = S_US_GO;
      // A lap beyond the count limit skips the update and goes straight to the mean.
      S_US_GO:     state_next = (tally >= MAX_LAPS) ? S_MEAN_GO : S_US_WAIT;
      S_US_WAIT:   if (div_done) state_next = S_UPDATE;
      S_UPDATE:    state_next = S_MEAN_GO;
      S_MEAN_GO:   state_next = (tally == '0) ? S_FIN : S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_done) state_next = S_MUS_GO;
      S_MUS_GO:    state_next = S_MUS_WAIT;
      S_MUS_WAIT: begin
        if (div_done) state_next = (tally < MIN_FOR_DEV) ? S_FIN : S_NM;
      end
      S_NM:        state_next = S_MU;
      S_MU:        state_next = S_C0;
      S_C0:        state_next = S_C1;
      S_C1:        state_next = S_C2;
      S_C2:        state_next = S_C3;
      S_C3:        state_next = S_VQ_GO;
      S_VQ_GO:     state_next = S_VQ_WAIT;
      S_VQ_WAIT:   if (div_done) state_next = S_VR_WAIT;
      S_VR_WAIT: begin
        if (div_done) state_next = rt_start ? S_RT_WAIT : S_FIN;
      end
      S_RT_WAIT:   if (rt_done) state_next = S_FIN;
      S_FIN:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control state and running statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tally     <= '0;
      sum_ns    <= '0;
      sum_us    <= '0;
      sum_sq    <= '0;
      min_seen  <= '1;
      max_seen  <= '0;
      drop_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPDATE) begin
        tally  <= tally + 1'b1;
        sum_ns <= sum_ns + {16'b0, lap};
        sum_us <= sum_us + {16'b0, us};
        sum_sq <= sum_sq + {15'b0, mul_p[45:0]};
        if (lap < min_seen) min_seen <= lap;
        if (lap > max_seen) max_seen <= lap;
      end
      if (state == S_US_GO && tally >= MAX_LAPS) drop_flag <= 1'b1;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) lap <= lap_ns & LAP_MASK;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_MEAN_GO: begin
        avg_ns <= '0;
        avg_us <= '0;
        dev    <= '0;
      end
      S_MEAN_WAIT: if (div_done) avg_ns <= div_q[31:0];
      S_MUS_WAIT:  if (div_done) avg_us <= div_q[US_W-1:0];
      // Sum of squared deviations: sum_sq - m * (2 * sum_us - n * m), modulo 2^64.
      S_MU: begin
        u   <= {24'b0, sum_us, 1'b0} - {16'b0, mul_p};
        acc <= {3'b0, sum_sq};
      end
      S_C1: acc <= acc - {16'b0, mul_p};
      S_C2: acc <= acc - {mul_p[39:0], 24'b0};
      S_C3: acc <= acc - {mul_p[15:0], 48'b0};
      S_VQ_WAIT: if (div_done) vq <= div_q;
      S_VR_WAIT: if (div_done && !rt_start) dev <= DEV_MAX;
      S_RT_WAIT: begin
        if (rt_done) dev <= rt_root[31] ? DEV_MAX : rt_root[DEV_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      lap_total       <= tally;
      mean_ns         <= avg_ns;
      mean_us         <= avg_us;
      shortest_ns     <= (tally == '0) ? '0 : min_seen;
      longest_ns      <= (tally == '0) ? '0 : max_seen;
      deviation_us_q8 <= dev;
      overflowed      <= drop_flag;
    end
  end

endmodule

[design/lts_checker.sv]
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks for the lap time statistics block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_checker
  import lts_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CNT_W-1:0] lap_total,
  input logic [31:0]      mean_ns,
  input logic [31:0]      shortest_ns,
  input logic [31:0]      longest_ns,
  input logic [DEV_W-1:0] deviation_us_q8,
  input logic             overflowed
);

  // Only one request is in work at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is still in work");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(lap_total) &&
                                  $stable(deviation_us_q8)))
    else $error("stalled result changed");

  a_sticky_overflow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |=> (!out_valid || overflowed))
    else $error("overflowed flag cleared without reset");

  a_no_dev_below_two: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lap_total < MIN_FOR_DEV) |-> (deviation_us_q8 == '0))
    else $error("deviation reported with fewer than two laps");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lap_total != '0) |->
      (shortest_ns <= mean_ns && mean_ns <= longest_ns))
    else $error("mean outside the shortest to longest range");

endmodule

bind lap_time_statistics_core lts_checker u_lts_checker (.*);
